// File: src/radix_literal_to_decimal_rewriter_assert.svh
// Assertion macros used by the radix literal rewriter command queue.
// Each macro takes a label, clock, active-low reset, the two sides of the
// implication and a message string.
`ifndef RADIX_LITERAL_TO_DECIMAL_REWRITER_ASSERT_SVH
`define RADIX_LITERAL_TO_DECIMAL_REWRITER_ASSERT_SVH

// Same-cycle implication.
`define RLDR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RLDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/rldr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rldr_pkg
// Shared constants and the command type passed from scanner to emitter.
// ----------------------------------------------------------------------------
package rldr_pkg;

    // ASCII codes
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_X     = 8'h78;
    localparam logic [7:0] ASCII_B     = 8'h62;
    localparam logic [7:0] ASCII_A_LOW = 8'h61;
    localparam logic [7:0] ASCII_F_LOW = 8'h66;
    localparam logic [7:0] ASCII_A_UP  = 8'h41;
    localparam logic [7:0] ASCII_F_UP  = 8'h46;

    // Characters one input item can queue after an optional decimal literal
    localparam int MAX_CHARS = 3;

    // Command control: decimal first (if dec), then nchr plain characters
    typedef struct packed {
        logic                            dec;
        logic [1:0]                      nchr;
        logic [MAX_CHARS-1:0][7:0]       chr;
        logic                            last;
    } t_cmd_ctl;

endpackage

// File: src/radix_literal_to_decimal_rewriter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_literal_to_decimal_rewriter
// Rewrites 0x / 0b literals in a byte stream as plain decimal text.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata          tlast          tuser
// s_*       in   [7:0] in_char  in_last        -
// m_*       out  [7:0] out_char out_last       -
//
// The scanner takes one item per cycle while the queue has room; the emitter
// takes a command from the queue while idle and then sends its bytes, and it
// takes no new command until the last byte of the current one is sent.
// A decimal literal is taken as a command, shifted VALUE_BITS times through the
// shift-and-add-three converter, stripped of leading zeros, then sent digit by
// digit. An accepted input item passes through the queue and the emitter's
// command register before it reaches the output register.
// Reset (synchronous, active low) clears scan state, queue and output valid.
// The scanner stalls only when the two-entry queue is full; the output
// register holds while m_tready is low.
// ----------------------------------------------------------------------------
module radix_literal_to_decimal_rewriter #(
    parameter int VALUE_BITS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_char
    input  logic       i_s_tlast,   // in_last
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_char
    output logic       o_m_tlast    // out_last
);
    import rldr_pkg::*;

    logic                  push, pop, full, empty;
    t_cmd_ctl              f_ctl, q_ctl;
    logic [VALUE_BITS-1:0] f_value, q_value;

    rldr_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_char  (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_push  (push),
        .o_ctl   (f_ctl),
        .o_value (f_value),
        .i_full  (full)
    );

    rldr_cmd_fifo #(.VALUE_BITS(VALUE_BITS)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ctl   (f_ctl),
        .i_value (f_value),
        .o_full  (full),
        .i_pop   (pop),
        .o_ctl   (q_ctl),
        .o_value (q_value),
        .o_empty (empty)
    );

    rldr_back #(.VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_ctl   (q_ctl),
        .i_value (q_value),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_char  (o_m_tdata),
        .o_last  (o_m_tlast)
    );

endmodule

// File: src/rldr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rldr_front
// Scanner: accepts bytes, tracks prefix and literal state, builds commands.
// ----------------------------------------------------------------------------
module rldr_front #(
    parameter int VALUE_BITS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [7:0]               i_char,
    input  logic                     i_last,
    output logic                     o_push,
    output rldr_pkg::t_cmd_ctl       o_ctl,
    output logic [VALUE_BITS-1:0]    o_value,
    input  logic                     i_full
);
    import rldr_pkg::*;

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_ZERO = 3'd1;
    localparam logic [2:0] M_PX   = 3'd2;
    localparam logic [2:0] M_PB   = 3'd3;
    localparam logic [2:0] M_DX   = 3'd4;
    localparam logic [2:0] M_DB   = 3'd5;

    // Digit value of c, or 16 when c is no hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= ASCII_A_LOW && c <= ASCII_F_LOW) ||
                     (c >= ASCII_A_UP && c <= ASCII_F_UP)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end else begin
            v = 5'd16;
        end
        return v;
    endfunction

    logic [2:0]            r_mode, n_mode;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic [VALUE_BITS-1:0] dval;
    logic [4:0]            dig;
    logic [1:0]            k;
    logic                  accept;
    t_cmd_ctl              cmd;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    // Classify the byte and build the command it causes
    always_comb begin
        n_mode  = r_mode;
        n_value = r_value;
        dval    = r_value;
        cmd     = '0;
        k       = 2'd0;
        dig     = hex_value(i_char);
        if (accept) begin
            unique case (r_mode) inside
                M_ZERO: begin
                    if (i_char == ASCII_X) begin
                        n_mode = M_PX;
                    end else if (i_char == ASCII_B) begin
                        n_mode = M_PB;
                    end else begin
                        cmd.chr[k] = ASCII_ZERO;
                        k = k + 2'd1;
                        if (i_char == ASCII_ZERO) begin
                            n_mode = M_ZERO;
                        end else begin
                            cmd.chr[k] = i_char;
                            k = k + 2'd1;
                            n_mode = M_IDLE;
                        end
                    end
                end
                M_PX, M_PB: begin
                    if ((r_mode == M_PX && !dig[4]) ||
                        (r_mode == M_PB && dig[4:1] == 4'd0)) begin
                        n_value = VALUE_BITS'(dig[3:0]);
                        n_mode  = (r_mode == M_PX) ? M_DX : M_DB;
                    end else begin
                        cmd.chr[k] = ASCII_ZERO;
                        k = k + 2'd1;
                        cmd.chr[k] = (r_mode == M_PX) ? ASCII_X : ASCII_B;
                        k = k + 2'd1;
                        if (i_char == ASCII_ZERO) begin
                            n_mode = M_ZERO;
                        end else begin
                            cmd.chr[k] = i_char;
                            k = k + 2'd1;
                            n_mode = M_IDLE;
                        end
                    end
                end
                M_DX: begin
                    if (!dig[4]) begin
                        n_value = {r_value[VALUE_BITS-5:0], dig[3:0]};
                    end else begin
                        cmd.dec = 1'b1;
                        dval    = r_value;
                        n_value = '0;
                        if (i_char == ASCII_ZERO) begin
                            n_mode = M_ZERO;
                        end else begin
                            cmd.chr[k] = i_char;
                            k = k + 2'd1;
                            n_mode = M_IDLE;
                        end
                    end
                end
                M_DB: begin
                    if (dig[4:1] == 4'd0) begin
                        n_value = {r_value[VALUE_BITS-2:0], dig[0]};
                    end else begin
                        cmd.dec = 1'b1;
                        dval    = r_value;
                        n_value = '0;
                        if (i_char == ASCII_ZERO) begin
                            n_mode = M_ZERO;
                        end else begin
                            cmd.chr[k] = i_char;
                            k = k + 2'd1;
                            n_mode = M_IDLE;
                        end
                    end
                end
                default: begin
                    if (i_char == ASCII_ZERO) begin
                        n_mode = M_ZERO;
                    end else begin
                        cmd.chr[k] = i_char;
                        k = k + 2'd1;
                        n_mode = M_IDLE;
                    end
                end
            endcase

            // Flush whatever is held on the final byte
            if (i_last) begin
                unique case (n_mode) inside
                    M_ZERO: begin
                        cmd.chr[k] = ASCII_ZERO;
                        k = k + 2'd1;
                    end
                    M_PX, M_PB: begin
                        cmd.chr[k] = ASCII_ZERO;
                        k = k + 2'd1;
                        cmd.chr[k] = (n_mode == M_PX) ? ASCII_X : ASCII_B;
                        k = k + 2'd1;
                    end
                    M_DX, M_DB: begin
                        cmd.dec = 1'b1;
                        dval    = n_value;
                    end
                    default: begin
                    end
                endcase
                n_mode   = M_IDLE;
                n_value  = '0;
                cmd.last = 1'b1;
            end
        end
        cmd.nchr = k;
    end

    assign o_push  = accept && (cmd.dec || k != 2'd0);
    assign o_ctl   = cmd;
    assign o_value = dval;

    // Hold scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_value <= '0;
        end else begin
            r_mode  <= n_mode;
            r_value <= n_value;
        end
    end

endmodule

// File: src/rldr_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rldr_cmd_fifo
// Two-entry command queue between scanner and emitter.
// ----------------------------------------------------------------------------
module rldr_cmd_fifo #(
    parameter int VALUE_BITS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  rldr_pkg::t_cmd_ctl       i_ctl,
    input  logic [VALUE_BITS-1:0]    i_value,
    output logic                     o_full,
    input  logic                     i_pop,
    output rldr_pkg::t_cmd_ctl       o_ctl,
    output logic [VALUE_BITS-1:0]    o_value,
    output logic                     o_empty
);
    import rldr_pkg::*;

`include "radix_literal_to_decimal_rewriter_assert.svh"

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    t_cmd_ctl              r_ctl_mem [DEPTH];
    logic [VALUE_BITS-1:0] r_val_mem [DEPTH];
    logic [PW-1:0]         r_wp, n_wp, r_rp, n_rp;
    logic [PW:0]           r_cnt, n_cnt;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_ctl   = r_ctl_mem[r_rp];
    assign o_value = r_val_mem[r_rp];

    // Advance pointers and fill count
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + PW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (PW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctl_mem[r_wp] <= i_ctl;
            r_val_mem[r_wp] <= i_value;
        end
    end

    `RLDR_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `RLDR_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")
    `RLDR_ASSERT_NOW(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= (PW+1)'(DEPTH), "count overrun")
    `RLDR_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, i_push && !i_pop, !o_empty, "push lost")

endmodule

// File: src/rldr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rldr_back
// Emitter: converts literal values to decimal and sends command bytes.
// ----------------------------------------------------------------------------
module rldr_back #(
    parameter int VALUE_BITS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_empty,
    input  rldr_pkg::t_cmd_ctl       i_ctl,
    input  logic [VALUE_BITS-1:0]    i_value,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [7:0]               o_char,
    output logic                     o_last
);
    import rldr_pkg::*;

    // Decimal digits needed for the widest value
    localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCDW = NDIG * 4;
    localparam int CW   = $clog2(VALUE_BITS + 1);
    localparam int DW   = $clog2(NDIG + 1);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_CONV = 2'd1;
    localparam logic [1:0] B_DEC  = 2'd2;
    localparam logic [1:0] B_CHR  = 2'd3;

    logic [1:0]            r_st, n_st;
    t_cmd_ctl              r_ctl, n_ctl;
    logic [VALUE_BITS-1:0] r_bin, n_bin;
    logic [BCDW-1:0]       r_bcd, n_bcd, bcd_adj;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [DW-1:0]         r_dleft, n_dleft;
    logic                  r_lead, n_lead;
    logic [1:0]            r_ci, n_ci;
    logic                  r_ovalid, n_ovalid;
    logic [7:0]            r_ochar, n_ochar;
    logic                  r_olast, n_olast;
    logic                  slot;
    logic [3:0]            top;

    assign slot = !r_ovalid || i_ready;
    assign top  = r_bcd[BCDW-1 -: 4];

    // Add three to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            bcd_adj[i*4 +: 4] = (r_bcd[i*4 +: 4] >= 4'd5) ?
                                r_bcd[i*4 +: 4] + 4'd3 : r_bcd[i*4 +: 4];
        end
    end

    // Sequence conversion and byte emission
    always_comb begin
        n_st     = r_st;
        n_ctl    = r_ctl;
        n_bin    = r_bin;
        n_bcd    = r_bcd;
        n_cnt    = r_cnt;
        n_dleft  = r_dleft;
        n_lead   = r_lead;
        n_ci     = r_ci;
        n_ovalid = r_ovalid && !i_ready;
        n_ochar  = r_ochar;
        n_olast  = r_olast;
        o_pop    = 1'b0;
        unique case (r_st)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_ctl = i_ctl;
                    n_ci  = 2'd0;
                    if (i_ctl.dec) begin
                        n_bin = i_value;
                        n_bcd = '0;
                        n_cnt = CW'(VALUE_BITS);
                        n_st  = B_CONV;
                    end else begin
                        n_st  = B_CHR;
                    end
                end
            end
            B_CONV: begin
                n_bcd = {bcd_adj[BCDW-2:0], r_bin[VALUE_BITS-1]};
                n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_dleft = DW'(NDIG);
                    n_lead  = 1'b1;
                    n_st    = B_DEC;
                end
            end
            B_DEC: begin
                if (r_lead && top == 4'd0 && r_dleft != DW'(1)) begin
                    // drop a leading zero
                    n_bcd   = {r_bcd[BCDW-5:0], 4'd0};
                    n_dleft = r_dleft - DW'(1);
                end else if (slot) begin
                    n_ovalid = 1'b1;
                    n_ochar  = ASCII_ZERO + {4'd0, top};
                    n_olast  = r_ctl.last && r_ctl.nchr == 2'd0 && r_dleft == DW'(1);
                    n_bcd    = {r_bcd[BCDW-5:0], 4'd0};
                    n_dleft  = r_dleft - DW'(1);
                    n_lead   = 1'b0;
                    if (r_dleft == DW'(1)) begin
                        n_st = (r_ctl.nchr != 2'd0) ? B_CHR : B_IDLE;
                    end
                end
            end
            B_CHR: begin
                if (slot) begin
                    n_ovalid = 1'b1;
                    n_ochar  = r_ctl.chr[r_ci];
                    n_olast  = r_ctl.last && (r_ci + 2'd1 == r_ctl.nchr);
                    n_ci     = r_ci + 2'd1;
                    if (r_ci + 2'd1 == r_ctl.nchr) begin
                        n_st = B_IDLE;
                    end
                end
            end
            default: begin
                n_st = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_ctl   <= n_ctl;
        r_bin   <= n_bin;
        r_bcd   <= n_bcd;
        r_cnt   <= n_cnt;
        r_dleft <= n_dleft;
        r_lead  <= n_lead;
        r_ci    <= n_ci;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
    end

    assign o_valid = r_ovalid;
    assign o_char  = r_ochar;
    assign o_last  = r_olast;

endmodule
